FILE: design/assert_macros.svh
// Assertion macros shared by the pulse generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property checked on every rising clock edge outside reset
`define TDWPG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Expression that must never be true outside reset
`define TDWPG_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define TDWPG_ASSERT(lbl, prop, msg)
`define TDWPG_NEVER(lbl, expr, msg)
`endif
`endif

FILE: design/tdwpg_pkg.sv
// Types and constants of the triggered dual-window pulse generator.
`timescale 1ns / 1ps
`default_nettype none
package tdwpg_pkg;

  // Width of the offset and width registers
  localparam int unsigned REG_WIDTH = 24;
  // Config index width (six registers)
  localparam int unsigned CFG_ADDR_WIDTH = 3;

  // Reset values, expressed in units of 600 ticks
  localparam int unsigned TICKS_PER_UNIT = 600;
  localparam int unsigned PERIOD_RESET   = 83 * TICKS_PER_UNIT;
  localparam logic [REG_WIDTH-1:0] OFFSET_A_RESET = REG_WIDTH'(15 * TICKS_PER_UNIT);
  localparam logic [REG_WIDTH-1:0] OFFSET_B_RESET = '0;
  localparam logic [REG_WIDTH-1:0] WIDTH_RESET    = REG_WIDTH'(10 * TICKS_PER_UNIT);

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_WIDTH-1:0] {
    CFG_OFFSET_A = 3'd0,
    CFG_WIDTH_A  = 3'd1,
    CFG_INVERT_A = 3'd2,
    CFG_OFFSET_B = 3'd3,
    CFG_WIDTH_B  = 3'd4,
    CFG_INVERT_B = 3'd5
  } cfg_reg_e;

  // Settings of one output channel
  typedef struct packed {
    logic [REG_WIDTH-1:0] offset;
    logic [REG_WIDTH-1:0] width;
    logic                 invert;
  } chan_cfg_t;

endpackage
`default_nettype wire

FILE: design/triggered_dual_window_pulse_generator_unit.sv
// Top level of the triggered dual-window pulse generator.
`timescale 1ns / 1ps
`default_nettype none
// One input transaction per timebase tick carries the trigger level; every
// transaction yields exactly one output transaction with the two channel pin
// levels, in order. A rising trigger edge restarts the elapsed-tick counter and
// latches the ticks since the previous edge as the period. Each channel is
// active strictly inside (offset, offset + width) and again in the same window
// shifted by half the period, then XORed with its invert bit. Throughput is one
// transaction per cycle while the output is not stalled; each result passes
// through the counter registers, then the output register holding the window
// compare. Configuration writes are accepted in every cycle and must only be
// issued while no transaction is pending in the block.
`include "assert_macros.svh"
module triggered_dual_window_pulse_generator_unit #(
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Input stream
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  wire logic [7:0]                          s_axis_tdata,  // [0] trigger_level
  // Output stream
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  output logic [7:0]                               m_axis_tdata,  // [0] out_a, [1] out_b
  // Configuration write channel
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [tdwpg_pkg::CFG_ADDR_WIDTH-1:0] cfg_addr_i,
  input  wire logic [tdwpg_pkg::REG_WIDTH-1:0]      cfg_data_i
);

  tdwpg_pkg::chan_cfg_t   cfg_a_q, cfg_a_d, cfg_b_q, cfg_b_d;
  logic                   s_accept;
  logic                   s1_valid_q, s1_valid_d;
  logic                   s2_load;
  logic                   out_valid_q, out_valid_d;
  logic [1:0]             out_data_q;
  logic                   last_level;
  logic [COUNT_WIDTH-1:0] elapsed;
  logic [COUNT_WIDTH-1:0] period;
  logic                   level_a, level_b;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_a_d = cfg_a_q;
    cfg_b_d = cfg_b_q;
    if (cfg_valid_i) begin
      case (tdwpg_pkg::cfg_reg_e'(cfg_addr_i))
        tdwpg_pkg::CFG_OFFSET_A: cfg_a_d.offset = cfg_data_i;
        tdwpg_pkg::CFG_WIDTH_A:  cfg_a_d.width  = cfg_data_i;
        tdwpg_pkg::CFG_INVERT_A: cfg_a_d.invert = cfg_data_i[0];
        tdwpg_pkg::CFG_OFFSET_B: cfg_b_d.offset = cfg_data_i;
        tdwpg_pkg::CFG_WIDTH_B:  cfg_b_d.width  = cfg_data_i;
        tdwpg_pkg::CFG_INVERT_B: cfg_b_d.invert = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_a_q <= '{offset: tdwpg_pkg::OFFSET_A_RESET, width: tdwpg_pkg::WIDTH_RESET,
                   invert: 1'b1};
      cfg_b_q <= '{offset: tdwpg_pkg::OFFSET_B_RESET, width: tdwpg_pkg::WIDTH_RESET,
                   invert: 1'b0};
    end else begin
      cfg_a_q <= cfg_a_d;
      cfg_b_q <= cfg_b_d;
    end
  end

  // Flow control: counter registers form stage 1, output register stage 2
  assign s2_load       = s1_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~s1_valid_q | s2_load;
  assign s_accept      = s_axis_tvalid & s_axis_tready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s_accept) begin
      s1_valid_d = 1'b1;
    end else if (s2_load) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s2_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Edge detect and counters, updated once per accepted transaction
  tdwpg_timebase #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_timebase (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (s_accept),
    .level_i      (s_axis_tdata[0]),
    .last_level_o (last_level),
    .elapsed_o    (elapsed),
    .period_o     (period)
  );

  // Window compares for both channels
  tdwpg_window #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_window_a (
    .elapsed_i (elapsed),
    .period_i  (period),
    .cfg_i     (cfg_a_q),
    .level_o   (level_a)
  );

  tdwpg_window #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_window_b (
    .elapsed_i (elapsed),
    .period_i  (period),
    .cfg_i     (cfg_b_q),
    .level_o   (level_b)
  );

  // Output register
  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      out_data_q <= {level_b, level_a};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_data_q};

  // Checks
  `TDWPG_ASSERT(a_edge_clears_count,
    s_accept && s_axis_tdata[0] && !last_level |=> elapsed == '0,
    "rising trigger edge did not restart the elapsed count")
  `TDWPG_NEVER(a_no_overwrite_stage1,
    s1_valid_q && !s2_load && s_axis_tready,
    "input accepted while stage 1 still holds an unconsumed transaction")
  `TDWPG_ASSERT(a_out_from_stage1,
    $rose(out_valid_q) |-> $past(s1_valid_q),
    "output became valid without a transaction in stage 1")

endmodule
`default_nettype wire

FILE: design/tdwpg_timebase.sv
// Trigger edge detector, saturating elapsed-tick counter and period latch.
`timescale 1ns / 1ps
`default_nettype none
module tdwpg_timebase #(
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   en_i,
  input  wire logic                   level_i,
  output logic                        last_level_o,
  output logic [COUNT_WIDTH-1:0]      elapsed_o,
  output logic [COUNT_WIDTH-1:0]      period_o
);

  localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

  logic                   last_q, last_d;
  logic [COUNT_WIDTH-1:0] elapsed_q, elapsed_d;
  logic [COUNT_WIDTH-1:0] period_q, period_d;
  logic [COUNT_WIDTH-1:0] elapsed_inc;
  logic                   rising;

  // Saturating increment, shared by the counter and the period capture
  assign elapsed_inc = (elapsed_q == CountMax) ? CountMax : elapsed_q + 1'b1;
  assign rising      = level_i & ~last_q;

  // Next state for one accepted tick
  always_comb begin
    last_d    = last_q;
    elapsed_d = elapsed_q;
    period_d  = period_q;
    if (en_i) begin
      last_d = level_i;
      if (rising) begin
        period_d  = elapsed_inc;
        elapsed_d = '0;
      end else begin
        elapsed_d = elapsed_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q    <= 1'b0;
      elapsed_q <= '0;
      period_q  <= COUNT_WIDTH'(tdwpg_pkg::PERIOD_RESET);
    end else begin
      last_q    <= last_d;
      elapsed_q <= elapsed_d;
      period_q  <= period_d;
    end
  end

  assign last_level_o = last_q;
  assign elapsed_o    = elapsed_q;
  assign period_o     = period_q;

endmodule
`default_nettype wire

FILE: design/tdwpg_window.sv
// Dual-window compare for one channel, with output inversion.
`timescale 1ns / 1ps
`default_nettype none
module tdwpg_window #(
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  wire logic [COUNT_WIDTH-1:0] elapsed_i,
  input  wire logic [COUNT_WIDTH-1:0] period_i,
  input  wire tdwpg_pkg::chan_cfg_t   cfg_i,
  output logic                        level_o
);

  // Room for half period + offset + width without wrap
  localparam int unsigned SumWidth =
    ((COUNT_WIDTH > tdwpg_pkg::REG_WIDTH) ? COUNT_WIDTH : tdwpg_pkg::REG_WIDTH) + 2;

  logic [SumWidth-1:0] t, half, off, len;
  logic [SumWidth-1:0] hi1, lo2, hi2;
  logic                active;

  assign t    = SumWidth'(elapsed_i);
  assign half = SumWidth'(period_i >> 1);
  assign off  = SumWidth'(cfg_i.offset);
  assign len  = SumWidth'(cfg_i.width);

  // Window bounds: first window after the trigger, second shifted by half a period
  assign hi1 = off + len;
  assign lo2 = half + off;
  assign hi2 = lo2 + len;

  assign active  = ((t > off) && (t < hi1)) || ((t > lo2) && (t < hi2));
  assign level_o = active ^ cfg_i.invert;

endmodule
`default_nettype wire
